### sv/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg: shared definitions for the biquad cascade lowpass filter
// Holds field widths, register indexes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package bqc_pkg;

  localparam int SAMPLE_W  = 16;  // width of the sample ports
  localparam int COEF_W    = 18;  // Q2.16 coefficient register width
  localparam int CFG_IDX_W = 3;   // configuration register index width
  localparam int CNT_W     = 2;   // width of the active section count
  localparam int SEC_IDX_W = 1;   // section index, enough for two sections

  localparam int DEF_SECTIONS       = 2;
  localparam int DEF_COEF_FRAC_BITS = 16;
  localparam int DEF_SAMPLE_BITS    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE = 3'd0,
    REG_GAIN_1 = 3'd1,
    REG_FB1_1  = 3'd2,
    REG_FB2_1  = 3'd3,
    REG_GAIN_2 = 3'd4,
    REG_FB1_2  = 3'd5,
    REG_FB2_2  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_GAIN = 2'd0,
    MUL_FB1  = 2'd1,
    MUL_FB2  = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic                 load;
    mul_sel_t             mul_sel;
    logic                 round;
    logic                 upd_z0;
    logic                 upd_z1;
    logic                 out_load;
    logic [SEC_IDX_W-1:0] sec;
  } bqc_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_active;
    logic             out_free;
  } bqc_status_t;

endpackage

### sv/bqc_in_if.sv
// ----------------------------------------------------------------------------
// bqc_in_if: sample input channel
// Valid/ready channel carrying one input sample and its flags.
// ----------------------------------------------------------------------------
interface bqc_in_if
  import bqc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       clear_state;
  logic                       last_in;

  modport source (output valid, output sample_in, output clear_state, output last_in,
                  input ready);
  modport sink   (input valid, input sample_in, input clear_state, input last_in,
                  output ready);
endinterface

### sv/bqc_out_if.sv
// ----------------------------------------------------------------------------
// bqc_out_if: filtered sample output channel
// Valid/ready channel carrying one filtered sample and its record flag.
// ----------------------------------------------------------------------------
interface bqc_out_if
  import bqc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       last_out;

  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

### sv/bqc_cfg_if.sv
// ----------------------------------------------------------------------------
// bqc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bqc_cfg_if
  import bqc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/bqc_ctrl.sv
// ----------------------------------------------------------------------------
// bqc_ctrl: sequencing controller
// Steps the shared multiplier through gain, rounding and feedback per section.
// ----------------------------------------------------------------------------
module bqc_ctrl
  import bqc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  bqc_status_t status,
  output bqc_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL_B  = 7'b0000010,
    S_ROUND  = 7'b0000100,
    S_MUL_A1 = 7'b0001000,
    S_UPD_Z0 = 7'b0010000,
    S_UPD_Z1 = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SEC_IDX_W-1:0] sec_r, sec_nxt;
  logic                 last_sec;

  assign last_sec = (CNT_W'(sec_r) + CNT_W'(1)) == status.n_active;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    sec_nxt      = sec_r;
    cmd          = '0;
    cmd.mul_sel  = MUL_GAIN;
    cmd.sec      = sec_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          sec_nxt   = '0;
          state_nxt = (status.n_active == '0) ? S_OUT : S_MUL_B;
        end
      end
      S_MUL_B: begin
        cmd.mul_sel = MUL_GAIN;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        state_nxt = S_MUL_A1;
      end
      S_MUL_A1: begin
        cmd.mul_sel = MUL_FB1;
        state_nxt   = S_UPD_Z0;
      end
      S_UPD_Z0: begin
        cmd.upd_z0  = 1'b1;
        cmd.mul_sel = MUL_FB2;
        state_nxt   = S_UPD_Z1;
      end
      S_UPD_Z1: begin
        cmd.upd_z1 = 1'b1;
        if (last_sec) begin
          state_nxt = S_OUT;
        end else begin
          sec_nxt   = sec_r + SEC_IDX_W'(1);
          state_nxt = S_MUL_B;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
    end
  end

  // The output register is only written when its previous item has gone.
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  // Passthrough skips the datapath sequence entirely.
  a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && status.n_active == '0) |=> (state_r == S_OUT))
    else $error("passthrough did not go straight to output");

  // The section index stays below the active count while sections run.
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL_B || state_r == S_ROUND || state_r == S_MUL_A1 ||
     state_r == S_UPD_Z0 || state_r == S_UPD_Z1)
    |-> (CNT_W'(sec_r) < status.n_active))
    else $error("section index beyond active count");

  // Once the result is placed, the controller is ready for the next item.
  a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_ready)
    else $error("controller did not return to idle after output");

endmodule

### sv/bqc_datapath.sv
// ----------------------------------------------------------------------------
// bqc_datapath: biquad arithmetic, delay and coefficient storage
// One shared multiplier, rounding/saturation, delay update and output register.
// ----------------------------------------------------------------------------
module bqc_datapath
  import bqc_pkg::*;
#(
  parameter int SECTIONS       = DEF_SECTIONS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bqc_cmd_t                   cmd,
  output bqc_status_t                status,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       in_clear,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_data
);

  localparam int XW    = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int PW    = COEF_W + XW;
  localparam int ACC_W = PW + 2;
  localparam int SUM_W = PW + 3;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // Configuration registers.
  logic [CNT_W-1:0]         act_r;
  logic signed [COEF_W-1:0] gain_r [SECTIONS];
  logic signed [COEF_W-1:0] fb1_r  [SECTIONS];
  logic signed [COEF_W-1:0] fb2_r  [SECTIONS];

  // Delay line, two words per section.
  logic signed [31:0] z0_r [SECTIONS];
  logic signed [31:0] z1_r [SECTIONS];

  logic signed [XW-1:0]       x_r, y_r, y_nxt, mul_op;
  logic signed [COEF_W-1:0]   mul_coef;
  logic signed [PW-1:0]       prod_r, prod_nxt, bx_r;
  logic signed [ACC_W-1:0]    acc, shf;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [SUM_W-1:0]    s0, s1;
  logic                       last_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_nxt;
  logic                       out_last_r;

  function automatic logic signed [31:0] sat_z(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (&v[SUM_W-1:31]) | ~(|v[SUM_W-1:31]);
    if (fits) begin
      sat_z = v[31:0];
    end else begin
      sat_z = {v[SUM_W-1], {31{~v[SUM_W-1]}}};
    end
  endfunction

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      MUL_GAIN: begin
        mul_coef = gain_r[cmd.sec];
        mul_op   = x_r;
      end
      MUL_FB1: begin
        mul_coef = fb1_r[cmd.sec];
        mul_op   = y_r;
      end
      MUL_FB2: begin
        mul_coef = fb2_r[cmd.sec];
        mul_op   = y_r;
      end
      default: begin
        mul_coef = gain_r[cmd.sec];
        mul_op   = x_r;
      end
    endcase
  end

  assign prod_nxt = mul_coef * mul_op;

  // Section output: round half up, floor shift, saturate to SAMPLE_BITS.
  always_comb begin
    acc = ACC_W'(prod_r) + ACC_W'(z0_r[cmd.sec]) + RND;
    shf = acc >>> COEF_FRAC_BITS;
    if ((&shf[ACC_W-1:SAMPLE_BITS-1]) | ~(|shf[ACC_W-1:SAMPLE_BITS-1])) begin
      y_sat = shf[SAMPLE_BITS-1:0];
    end else begin
      y_sat = {shf[ACC_W-1], {(SAMPLE_BITS-1){~shf[ACC_W-1]}}};
    end
    y_nxt = XW'(y_sat);
  end

  assign s0 = (SUM_W'(bx_r) <<< 1) - SUM_W'(prod_r) + SUM_W'(z1_r[cmd.sec]);
  assign s1 = SUM_W'(bx_r) - SUM_W'(prod_r);

  // Final saturation to the port width.
  always_comb begin
    if ((&x_r[XW-1:SAMPLE_W-1]) | ~(|x_r[XW-1:SAMPLE_W-1])) begin
      out_nxt = x_r[SAMPLE_W-1:0];
    end else begin
      out_nxt = {x_r[XW-1], {(SAMPLE_W-1){~x_r[XW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.load) begin
      x_r    <= XW'(in_sample);
      last_r <= in_last;
    end
    if (cmd.round) begin
      bx_r <= prod_r;
      y_r  <= y_nxt;
    end
    if (cmd.upd_z1) begin
      x_r <= y_r;
    end
    if (cmd.out_load) begin
      out_sample_r <= out_nxt;
      out_last_r   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        z0_r[i] <= '0;
        z1_r[i] <= '0;
      end
    end else if (cmd.load && in_clear) begin
      for (int i = 0; i < SECTIONS; i++) begin
        z0_r[i] <= '0;
        z1_r[i] <= '0;
      end
    end else begin
      if (cmd.upd_z0) begin
        z0_r[cmd.sec] <= sat_z(s0);
      end
      if (cmd.upd_z1) begin
        z1_r[cmd.sec] <= sat_z(s1);
      end
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      for (int i = 0; i < SECTIONS; i++) begin
        gain_r[i] <= '0;
        fb1_r[i]  <= '0;
        fb2_r[i]  <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ACTIVE: act_r <= cfg_data[CNT_W-1:0];
        REG_GAIN_1: gain_r[0] <= cfg_data;
        REG_FB1_1:  fb1_r[0]  <= cfg_data;
        REG_FB2_1:  fb2_r[0]  <= cfg_data;
        REG_GAIN_2: begin
          if (SECTIONS > 1) gain_r[SECTIONS-1] <= cfg_data;
        end
        REG_FB1_2: begin
          if (SECTIONS > 1) fb1_r[SECTIONS-1] <= cfg_data;
        end
        REG_FB2_2: begin
          if (SECTIONS > 1) fb2_r[SECTIONS-1] <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_sample      = out_sample_r;
  assign out_last        = out_last_r;
  assign status.out_free = !out_valid_r || out_ready;
  assign status.n_active = (act_r > CNT_W'(SECTIONS)) ? CNT_W'(SECTIONS) : act_r;

endmodule

### sv/biquad_cascade_lowpass.sv
// ----------------------------------------------------------------------------
// biquad_cascade_lowpass: cascaded second-order IIR lowpass filter
// Up to two transposed direct form II sections on a shared multiplier.
// ----------------------------------------------------------------------------
// Each input item is one signed 16-bit sample; each produces exactly one
// output item. The block takes an item only when its controller is idle and
// then runs it through each active section in turn before the result sits
// in the output register; with no active section it goes straight there.
// Each section uses the single shared multiplier, which forms the gain
// product, then the two feedback products, with a rounding and saturation
// step between, and then updates that section's two delay words.
// The next item is accepted on the cycle after the result is placed, even
// while that result still waits to be taken downstream; a held output only
// stretches the final step of the following item.
// The numerator is fixed to the lowpass form (b1 = 2*b0, b2 = b0), so each
// section takes a gain and two feedback coefficients in Q2.COEF_FRAC_BITS.
// Setting clear_state zeroes every delay word before that sample is used.
// Configuration writes are always ready and should only be made while no
// item is in flight.
module biquad_cascade_lowpass
  import bqc_pkg::*;
#(
  parameter int SECTIONS       = DEF_SECTIONS,
  parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  bqc_in_if.sink    in_s,
  bqc_out_if.source out_s,
  bqc_cfg_if.sink   cfg_s
);

  // Command and status between the controller and the datapath.
  bqc_cmd_t    cmd;
  bqc_status_t status;
  logic        ctrl_in_ready;

  bqc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (ctrl_in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bqc_datapath #(
    .SECTIONS       (SECTIONS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_sample  (in_s.sample_in),
    .in_clear   (in_s.clear_state),
    .in_last    (in_s.last_in),
    .out_valid  (out_s.valid),
    .out_ready  (out_s.ready),
    .out_sample (out_s.sample_out),
    .out_last   (out_s.last_out),
    .cfg_valid  (cfg_s.valid),
    .cfg_ready  (cfg_s.ready),
    .cfg_index  (cfg_s.index),
    .cfg_data   (cfg_s.data)
  );

  // The controller alone decides when a new item is taken.
  assign in_s.ready = ctrl_in_ready;

endmodule
